FILE: hdl/fixed_point_q24_8_alu_assert.svh
// ----------------------------------------------------------------------------
// Q24.8 ALU assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_Q24_8_ALU_ASSERT_SVH
`define FIXED_POINT_Q24_8_ALU_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define FPQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// expression always holds
`define FPQ_ASSERT_ALW(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");

`endif

FILE: hdl/fpqalu_pkg.sv
// ----------------------------------------------------------------------------
// Q24.8 ALU package
// Opcodes, status codes and the sideband carried down the divider chain.
// ----------------------------------------------------------------------------
package fpqalu_pkg;

	localparam int FRAC_BITS_DEF = 8;

	typedef enum logic [3:0] {
		CMD_ADD  = 4'd0,
		CMD_SUB  = 4'd1,
		CMD_MUL  = 4'd2,
		CMD_DIV  = 4'd3,
		CMD_MIN  = 4'd4,
		CMD_MAX  = 4'd5,
		CMD_INC  = 4'd6,
		CMD_DEC  = 4'd7,
		CMD_FINT = 4'd8,
		CMD_TINT = 4'd9
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_DIV0 = 2'd2
	} status_t;

	typedef struct packed {
		logic [3:0]  cmd;
		logic        neg;
		logic        gt;
		logic        lt;
		logic        eq;
		logic [31:0] res;
		status_t     st;
		logic [63:0] prod;
	} side_t;

endpackage

FILE: hdl/fpqalu_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: one quotient bit per cell, registered.
// ----------------------------------------------------------------------------
module fpqalu_div_cell #(
	parameter int XW = 42
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  logic [32:0]         in_rem,
	input  logic [XW-1:0]       in_xq,
	input  logic [32:0]         in_den,
	input  fpqalu_pkg::side_t   in_side,
	output logic                out_vld,
	output logic [32:0]         out_rem,
	output logic [XW-1:0]       out_xq,
	output logic [32:0]         out_den,
	output fpqalu_pkg::side_t   out_side
);
	import fpqalu_pkg::*;

	logic [33:0] trial;
	logic [33:0] diff;
	logic        ge;
	logic        vld_q;
	logic [32:0] rem_q;
	logic [XW-1:0] xq_q;
	logic [32:0] den_q;
	side_t       side_q;

	always_comb begin
		trial = {in_rem, in_xq[XW-1]};
		ge    = trial >= {1'b0, in_den};
		diff  = trial - {1'b0, in_den};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		rem_q  <= ge ? diff[32:0] : trial[32:0];
		xq_q   <= {in_xq[XW-2:0], ge};
		den_q  <= in_den;
		side_q <= in_side;
	end

	assign out_vld  = vld_q;
	assign out_rem  = rem_q;
	assign out_xq   = xq_q;
	assign out_den  = den_q;
	assign out_side = side_q;

endmodule

FILE: hdl/fixed_point_q24_8_alu.sv
// ----------------------------------------------------------------------------
// Q24.8 fixed-point ALU
// Saturating add/sub/mul/div/min/max/inc/dec/conversions with compare flags.
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// command   in         start & !busy         cmd, operand_a, operand_b
// result    out        done (one cycle)      result_value, a_greater, a_less,
//                                            a_equal, status
//
// One transfer accepted every cycle; busy stays low.
// Every opcode passes through the input and sideband registers, the divider
// chain of 34 + FRACTION_BITS cells (one quotient bit per cell) and the output register.
// Reset clears the valid bits of the pipeline; no result from before reset appears after it.
// The receiver cannot stall: each result shows for one cycle.
// ----------------------------------------------------------------------------
`include "fixed_point_q24_8_alu_assert.svh"

module fixed_point_q24_8_alu #(
	parameter int FRACTION_BITS = fpqalu_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         cmd,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic               done,
	output logic signed [31:0] result_value,
	output logic               a_greater,
	output logic               a_less,
	output logic               a_equal,
	output logic [1:0]         status
);
	import fpqalu_pkg::*;

	localparam int XW  = 32 + FRACTION_BITS + 2;
	localparam int FW  = 33 + FRACTION_BITS;
	localparam int LAT = XW + 3;

	logic               vld_s1;
	logic [3:0]         cmd_s1;
	logic signed [31:0] a_s1;
	logic signed [31:0] b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= cmd;
		a_s1   <= operand_a;
		b_s1   <= operand_b;
	end

	side_t        side_c;
	logic [31:0]  ma;
	logic [31:0]  mb;
	logic [32:0]  sum;
	logic [32:0]  dif;
	logic [32:0]  incv;
	logic [32:0]  decv;
	logic signed [FW-1:0] fint;
	logic [XW-1:0] x_c;

	always_comb begin
		ma   = a_s1[31] ? 32'(-a_s1) : a_s1;
		mb   = b_s1[31] ? 32'(-b_s1) : b_s1;
		sum  = {a_s1[31], a_s1} + {b_s1[31], b_s1};
		dif  = {a_s1[31], a_s1} - {b_s1[31], b_s1};
		incv = {a_s1[31], a_s1} + 33'd1;
		decv = {a_s1[31], a_s1} - 33'd1;
		fint = FW'(a_s1) <<< FRACTION_BITS;
		x_c  = (XW'(ma) << (FRACTION_BITS + 1)) + XW'(mb);
		side_c      = '0;
		side_c.cmd  = cmd_s1;
		side_c.neg  = a_s1[31] ^ b_s1[31];
		side_c.gt   = a_s1 > b_s1;
		side_c.lt   = a_s1 < b_s1;
		side_c.eq   = a_s1 == b_s1;
		side_c.st   = ST_OK;
		side_c.prod = 64'(ma) * 64'(mb);
		unique case (cmd_s1)
			CMD_ADD: side_c.res = sum[31:0];
			CMD_SUB: side_c.res = dif[31:0];
			CMD_INC: side_c.res = incv[31:0];
			CMD_DEC: side_c.res = decv[31:0];
			CMD_MIN: side_c.res = (a_s1 <= b_s1) ? a_s1 : b_s1;
			CMD_MAX: side_c.res = (a_s1 <= b_s1) ? b_s1 : a_s1;
			CMD_FINT: side_c.res = fint[31:0];
			CMD_TINT: side_c.res = 32'(a_s1 >>> FRACTION_BITS);
			default: side_c.res = 32'd0;
		endcase
		priority if ((cmd_s1 == CMD_ADD && sum[32] != sum[31])
			|| (cmd_s1 == CMD_SUB && dif[32] != dif[31])
			|| (cmd_s1 == CMD_INC && incv[32] != incv[31])
			|| (cmd_s1 == CMD_DEC && decv[32] != decv[31])) begin
			side_c.st  = ST_OVF;
			side_c.res = a_s1[31] ? 32'h8000_0000 : 32'h7fff_ffff;
		end else if (cmd_s1 == CMD_FINT
			&& fint[FW-1:31] != {(FRACTION_BITS + 2){fint[FW-1]}}) begin
			side_c.st  = ST_OVF;
			side_c.res = a_s1[31] ? 32'h8000_0000 : 32'h7fff_ffff;
		end else if (cmd_s1 == CMD_DIV && b_s1 == 32'sd0) begin
			side_c.st  = ST_DIV0;
			side_c.res = 32'd0;
		end else begin
		end
	end

	logic          vld_w  [0:XW];
	logic [32:0]   rem_w  [0:XW];
	logic [XW-1:0] xq_w   [0:XW];
	logic [32:0]   den_w  [0:XW];
	side_t         side_w [0:XW];

	logic          vld_s2;
	logic [XW-1:0] xq_s2;
	logic [32:0]   den_s2;
	side_t         side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		xq_s2   <= x_c;
		den_s2  <= {mb, 1'b0};
		side_s2 <= side_c;
	end

	assign vld_w[0]  = vld_s2;
	assign rem_w[0]  = 33'd0;
	assign xq_w[0]   = xq_s2;
	assign den_w[0]  = den_s2;
	assign side_w[0] = side_s2;

	for (genvar i = 0; i < XW; i++) begin : g_cell
		fpqalu_div_cell #(.XW(XW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_vld   (vld_w[i]),
			.in_rem   (rem_w[i]),
			.in_xq    (xq_w[i]),
			.in_den   (den_w[i]),
			.in_side  (side_w[i]),
			.out_vld  (vld_w[i+1]),
			.out_rem  (rem_w[i+1]),
			.out_xq   (xq_w[i+1]),
			.out_den  (den_w[i+1]),
			.out_side (side_w[i+1])
		);
	end

	side_t       fs;
	logic [64:0] q;
	logic [31:0] res_c;
	status_t     st_c;

	always_comb begin
		fs    = side_w[XW];
		res_c = fs.res;
		st_c  = fs.st;
		if (fs.cmd == CMD_MUL) begin
			q = ({1'b0, fs.prod} + (65'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
		end else begin
			q = 65'(xq_w[XW]);
		end
		if ((fs.cmd == CMD_MUL) || (fs.cmd == CMD_DIV && fs.st != ST_DIV0)) begin
			if (fs.neg) begin
				if (q > 65'h0_8000_0000) begin
					res_c = 32'h8000_0000;
					st_c  = ST_OVF;
				end else begin
					res_c = 32'(-q[31:0]);
				end
			end else begin
				if (q > 65'h0_7fff_ffff) begin
					res_c = 32'h7fff_ffff;
					st_c  = ST_OVF;
				end else begin
					res_c = q[31:0];
				end
			end
		end
	end

	logic        done_q;
	logic [31:0] res_q;
	logic        gt_q;
	logic        lt_q;
	logic        eq_q;
	status_t     st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_w[XW];
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_c;
		gt_q  <= fs.gt;
		lt_q  <= fs.lt;
		eq_q  <= fs.eq;
		st_q  <= st_c;
	end

	assign busy         = 1'b0;
	assign done         = done_q;
	assign result_value = res_q;
	assign a_greater    = gt_q;
	assign a_less       = lt_q;
	assign a_equal      = eq_q;
	assign status       = st_q;

	`FPQ_ASSERT_IMP(a_done_lat, done, $past(start, LAT))
	`FPQ_ASSERT_IMP(a_div0_zero, done && status == ST_DIV0, result_value == 32'd0)
	`FPQ_ASSERT_IMP(a_flags_one, done, $onehot({a_greater, a_less, a_equal}))
	`FPQ_ASSERT_ALW(a_no_busy, !busy)

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Q24.8 ALU testbench
// Drives directed corner operations, then random commands with random gaps,
// and checks each result against an exact integer model of the ALU.
// ----------------------------------------------------------------------------
module tb;
	import fpqalu_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int LATENCY = FB + 37;
	localparam logic signed [63:0] MAXV = 64'sd2147483647;
	localparam logic signed [63:0] MINV = -64'sd2147483648;

	typedef struct {
		logic [3:0]         op;
		logic signed [31:0] a;
		logic signed [31:0] b;
		int                 gap;
	} alu_op_t;

	typedef struct {
		logic signed [31:0] value;
		logic               gt;
		logic               lt;
		logic               eq;
		logic [1:0]         st;
	} alu_res_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [3:0]         cmd;
	logic signed [31:0] operand_a;
	logic signed [31:0] operand_b;
	logic               done;
	logic signed [31:0] result_value;
	logic               a_greater;
	logic               a_less;
	logic               a_equal;
	logic [1:0]         status;

	alu_op_t  op_queue[$];
	alu_res_t expected_results[$];
	int       mismatches = 0;
	int       gap_left;

	fixed_point_q24_8_alu dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.operand_a(operand_a), .operand_b(operand_b), .done(done),
		.result_value(result_value), .a_greater(a_greater), .a_less(a_less),
		.a_equal(a_equal), .status(status)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic logic signed [63:0] saturate(input logic signed [63:0] v,
			inout logic [1:0] st);
		if (v > MAXV) begin
			st = ST_OVF;
			return MAXV;
		end
		if (v < MINV) begin
			st = ST_OVF;
			return MINV;
		end
		return v;
	endfunction

	function automatic alu_res_t compute_alu(input logic [3:0] op,
			input logic signed [31:0] a32, input logic signed [31:0] b32);
		alu_res_t r;
		logic signed [63:0] a, b, v;
		logic [63:0] ma, mb, q;
		logic [1:0] st;
		a = a32;
		b = b32;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		st = ST_OK;
		v = 0;
		case (op)
			CMD_ADD: v = saturate(a + b, st);
			CMD_SUB: v = saturate(a - b, st);
			CMD_MUL: begin
				q = (ma * mb + (64'd1 << (FB - 1))) >> FB;
				v = ((a < 0) != (b < 0)) ? -$signed(q) : $signed(q);
				v = saturate(v, st);
			end
			CMD_DIV: begin
				if (b == 0) begin
					st = ST_DIV0;
				end else begin
					q = (2 * (ma << FB) + mb) / (2 * mb);
					v = ((a < 0) != (b < 0)) ? -$signed(q) : $signed(q);
					v = saturate(v, st);
				end
			end
			CMD_MIN: v = (a <= b) ? a : b;
			CMD_MAX: v = (a <= b) ? b : a;
			CMD_INC: v = saturate(a + 1, st);
			CMD_DEC: v = saturate(a - 1, st);
			CMD_FINT: begin
				q = ma << FB;
				v = saturate((a < 0) ? -$signed(q) : $signed(q), st);
			end
			CMD_TINT: v = a >>> FB;
			default: v = 0;
		endcase
		r.value = v[31:0];
		r.gt = a > b;
		r.lt = a < b;
		r.eq = a == b;
		r.st = st;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	function automatic logic signed [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'sh7fffffff - $urandom_range(0, 3);
			1: return 32'sh80000000 + $urandom_range(0, 3);
			2: return $signed($urandom_range(0, 1023)) - 512;
			3: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
			4: return 32'(0);
			default: return $urandom;
		endcase
	endfunction

	task automatic push_op(input logic [3:0] op, input logic signed [31:0] a,
			input logic signed [31:0] b);
		alu_op_t t;
		t.op = op;
		t.a = a;
		t.b = b;
		t.gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
		op_queue.push_back(t);
	endtask

	// driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= CMD_ADD;
			operand_a <= 32'sd0;
			operand_b <= 32'sd0;
			gap_left <= 0;
		end else if (start && !busy) begin
			// transfer accepted at the last rising edge
			if (op_queue.size() != 0 && op_queue[0].gap == 0) begin
				cmd <= op_queue[0].op;
				operand_a <= op_queue[0].a;
				operand_b <= op_queue[0].b;
				expected_results.push_back(compute_alu(op_queue[0].op,
					op_queue[0].a, op_queue[0].b));
				void'(op_queue.pop_front());
			end else begin
				start <= 1'b0;
				if (op_queue.size() != 0) gap_left <= op_queue[0].gap - 1;
			end
		end else if (!start && op_queue.size() != 0) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
			end else begin
				start <= 1'b1;
				cmd <= op_queue[0].op;
				operand_a <= op_queue[0].a;
				operand_b <= op_queue[0].b;
				expected_results.push_back(compute_alu(op_queue[0].op,
					op_queue[0].a, op_queue[0].b));
				void'(op_queue.pop_front());
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		alu_res_t w;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", result_value, 32'd0);
			end else begin
				w = expected_results.pop_front();
				if (result_value !== w.value) report_mismatch("value", result_value, w.value);
				if (a_greater !== w.gt)
					report_mismatch("a_greater", 32'(a_greater), 32'(w.gt));
				if (a_less !== w.lt) report_mismatch("a_less", 32'(a_less), 32'(w.lt));
				if (a_equal !== w.eq) report_mismatch("a_equal", 32'(a_equal), 32'(w.eq));
				if (status !== w.st) report_mismatch("status", 32'(status), 32'(w.st));
			end
		end
	end

	initial begin
		logic [3:0] op;
		logic signed [31:0] a, b;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		push_op(CMD_ADD, 32'sh7fffffff, 32'sd1);
		push_op(CMD_ADD, 32'sh80000000, -32'sd1);
		push_op(CMD_SUB, 32'sh80000000, 32'sd1);
		push_op(CMD_SUB, 32'sh7fffffff, -32'sd1);
		push_op(CMD_MUL, 32'sh7fffffff, 32'sh7fffffff);
		push_op(CMD_MUL, 32'sh80000000, 32'sh80000000);
		push_op(CMD_MUL, 32'sd384, -32'sd128);
		push_op(CMD_MUL, 32'sd1, 32'sd128);
		push_op(CMD_DIV, 32'sd256, 32'sd0);
		push_op(CMD_DIV, 32'sh80000000, 32'sd1);
		push_op(CMD_DIV, 32'sh80000000, -32'sd256);
		push_op(CMD_DIV, -32'sd1, 32'sd512);
		push_op(CMD_MIN, 32'sd5, 32'sd5);
		push_op(CMD_MAX, 32'sh80000000, 32'sh7fffffff);
		push_op(CMD_INC, 32'sh7fffffff, 32'sd0);
		push_op(CMD_DEC, 32'sh80000000, 32'sd0);
		push_op(CMD_FINT, 32'sh00800000, 32'sd3);
		push_op(CMD_FINT, -32'sd8388609, 32'sd3);
		push_op(CMD_TINT, -32'sd1, 32'sd0);
		push_op(CMD_TINT, 32'sh80000000, 32'sd0);
		push_op(4'd10, 32'sd7, 32'sd9);
		push_op(4'd15, -32'sd7, 32'sd9);
		for (int i = 0; i < 1450; i++) begin
			op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
				: 4'($urandom_range(0, 9));
			a = pick_operand();
			b = ($urandom_range(0, 9) == 0) ? a : pick_operand();
			push_op(op, a, b);
		end
		wait (op_queue.size() == 0 && expected_results.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#500000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/fpqalu_pkg.sv
hdl/fpqalu_div_cell.sv
hdl/fixed_point_q24_8_alu.sv
test/tb.sv
